### rtl/mandelbrot_escape_time_pixel_macros.svh
// assertion macros for the mandelbrot escape time pixel block
// used by the port checker, no other dependencies
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_MACROS_SVH

// same-cycle implication, off while reset is low
`define MBE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mbe check failed");

// next-cycle implication, off while reset is low
`define MBE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mbe check failed");

`endif

### rtl/mbe_pkg.sv
// shared constants, types and state codes of the mandelbrot escape time pixel block
// no dependencies
package mbe_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 28;
  localparam int PITCH_FRAC = 28;

  localparam int IMG_W   = 12;
  localparam int CTR_W   = 16;
  localparam int PITCH_W = 28;
  localparam int BASE_W  = 24;
  localparam int CNT_W   = 12;
  localparam int CH_W    = 8;
  localparam int IDX_W   = 3;
  localparam int CFG_W   = 28;

  // Q8.F complex component
  localparam int Z_W  = FRAC_BITS + 8;
  // multiplier operand magnitude, operands stay within two
  localparam int OP_W = FRAC_BITS + 2;
  // signed product, magnitude within four
  localparam int P_W  = FRAC_BITS + 4;
  // half-pixel offset
  localparam int D_W  = ((COORD_BITS + 2 > 18) ? COORD_BITS + 2 : 18) + 2;

  localparam logic signed [Z_W-1:0] ZMAX = {1'b0, {(Z_W-1){1'b1}}};
  localparam logic signed [Z_W-1:0] ZMIN = {1'b1, {(Z_W-1){1'b0}}};

  typedef struct packed {
    logic [IMG_W-1:0]        width;
    logic [IMG_W-1:0]        height;
    logic signed [CTR_W-1:0] center_x;
    logic signed [CTR_W-1:0] center_y;
    logic [PITCH_W-1:0]      pitch;
    logic [CNT_W-1:0]        max_iter;
    logic [BASE_W-1:0]       base;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    width:    12'd900,
    height:   12'd700,
    center_x: 16'sd450,
    center_y: 16'sd350,
    pitch:    28'd671089,
    max_iter: 12'd42,
    base:     24'h00FF00
  };

  typedef enum logic [IDX_W-1:0] {
    REG_WIDTH,
    REG_HEIGHT,
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_PITCH,
    REG_MAX_ITER,
    REG_BASE
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP,
    ST_ZP,
    ST_UPD,
    ST_CHK,
    ST_SR,
    ST_SI,
    ST_TEST,
    ST_COLOR
  } st_e;

  typedef enum logic [1:0] {
    MUL_IDLE,
    MUL_LO,
    MUL_HI
  } mul_st_e;

  typedef struct packed {
    logic                  start;
    logic signed [Z_W-1:0] a;
    logic signed [Z_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                  done;
    logic signed [P_W-1:0] p;
  } mul_rsp_t;

endpackage

### rtl/mbe_cmap.sv
// pixel to complex plane mapping with one shared offset by pitch multiplier
// depends on mbe_pkg
module mbe_cmap (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  mbe_pkg::cfg_t                       cfg_i,
  input  logic [mbe_pkg::COORD_BITS-1:0]      px_i,
  input  logic [mbe_pkg::COORD_BITS-1:0]      py_i,
  output logic                                done_o,
  output logic signed [mbe_pkg::Z_W-1:0]      cr_o,
  output logic signed [mbe_pkg::Z_W-1:0]      ci_o
);
  import mbe_pkg::*;

  localparam int PR_W  = D_W + PITCH_W;
  localparam int CAP_W = PITCH_FRAC + 9;
  localparam int SH_L  = (FRAC_BITS >= PITCH_FRAC + 1) ? FRAC_BITS - PITCH_FRAC - 1 : 0;
  localparam int SH_R  = (FRAC_BITS >= PITCH_FRAC + 1) ? 0 : PITCH_FRAC + 1 - FRAC_BITS;
  localparam int MW    = CAP_W + SH_L;
  localparam logic [PR_W-1:0] CAP    = PR_W'(1) << (CAP_W - 1);
  localparam logic [Z_W-1:0]  ZLIM_U = Z_W'(1) << (Z_W - 1);

  localparam logic [1:0] STEP_IDLE = 2'd0;
  localparam logic [1:0] STEP_RE   = 2'd1;
  localparam logic [1:0] STEP_IM   = 2'd2;

  logic [1:0]               step_q;
  logic                     done_q;
  logic [PR_W-1:0]          prod_q;
  logic                     neg_q;
  logic signed [Z_W-1:0]    cr_q;
  logic signed [Z_W-1:0]    ci_q;

  logic signed [D_W-1:0]    x_s, y_s, w_s, h_s, hw_s, hh_s, cx_s, cy_s;
  logic signed [D_W-1:0]    dx, dy, d_sel;
  logic [D_W-1:0]           mag_d;
  logic [PR_W-1:0]          prod;
  logic [CAP_W-1:0]         capped;
  logic [MW-1:0]            shifted;
  logic [Z_W-1:0]           mag_z;
  logic signed [Z_W-1:0]    cval;

  assign x_s  = D_W'($signed({1'b0, px_i}));
  assign y_s  = D_W'($signed({1'b0, py_i}));
  assign w_s  = D_W'($signed({1'b0, cfg_i.width}));
  assign h_s  = D_W'($signed({1'b0, cfg_i.height}));
  assign hw_s = D_W'($signed({2'b00, cfg_i.width[IMG_W-1:1]}));
  assign hh_s = D_W'($signed({2'b00, cfg_i.height[IMG_W-1:1]}));
  assign cx_s = D_W'(cfg_i.center_x);
  assign cy_s = D_W'(cfg_i.center_y);

  // offsets in half pixels
  assign dx = (x_s <<< 1) + (cx_s <<< 1) - (hw_s <<< 1) - w_s;
  assign dy = h_s + (hh_s <<< 1) - (y_s <<< 1) - (cy_s <<< 1);

  assign d_sel = (step_q == STEP_RE) ? dy : dx;
  assign mag_d = d_sel[D_W-1] ? D_W'(-d_sel) : D_W'(d_sel);
  assign prod  = PR_W'(mag_d) * PR_W'(cfg_i.pitch);

  always_comb begin
    capped  = (prod_q > CAP) ? CAP[CAP_W-1:0] : prod_q[CAP_W-1:0];
    shifted = (MW'(capped) << SH_L) >> SH_R;
    mag_z   = shifted[Z_W-1:0];
    if (neg_q) begin
      cval = (mag_z >= ZLIM_U) ? ZMIN : -$signed(mag_z);
    end else begin
      cval = (mag_z >= ZLIM_U) ? ZMAX : $signed(mag_z);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
      done_q <= 1'b0;
    end else begin
      done_q <= (step_q == STEP_IM);
      if (start_i) begin
        step_q <= STEP_RE;
      end else if (step_q == STEP_RE) begin
        step_q <= STEP_IM;
      end else begin
        step_q <= STEP_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i || step_q == STEP_RE) begin
      prod_q <= prod;
      neg_q  <= d_sel[D_W-1];
    end
    if (step_q == STEP_RE) begin
      cr_q <= cval;
    end
    if (step_q == STEP_IM) begin
      ci_q <= cval;
    end
  end

  assign done_o = done_q;
  assign cr_o   = cr_q;
  assign ci_o   = ci_q;

endmodule

### rtl/mbe_mul.sv
// shared fixed-point multiplier, two partial products in the MUL_LO and MUL_HI states
// depends on mbe_pkg
module mbe_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mbe_pkg::mul_req_t req_i,
  output mbe_pkg::mul_rsp_t rsp_o
);
  import mbe_pkg::*;

  localparam int H_W   = (OP_W + 1) / 2;
  localparam int PP_W  = OP_W + H_W;
  localparam int ACC_W = 2 * OP_W;

  mul_st_e          st_q, st_d;
  logic             done_q, done_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic [OP_W-1:0]  ma_q, mb_q;
  logic             neg_q;

  logic [Z_W-1:0]   abs_a, abs_b;
  logic [H_W-1:0]   b_part;
  logic [PP_W-1:0]  pp;
  logic [P_W-1:0]   mag;

  assign abs_a  = req_i.a[Z_W-1] ? Z_W'(-req_i.a) : Z_W'(req_i.a);
  assign abs_b  = req_i.b[Z_W-1] ? Z_W'(-req_i.b) : Z_W'(req_i.b);
  assign b_part = (st_q == MUL_LO) ? mb_q[H_W-1:0] : H_W'(mb_q[OP_W-1:H_W]);
  assign pp     = PP_W'(ma_q) * PP_W'(b_part);

  always_comb begin
    st_d   = st_q;
    acc_d  = acc_q;
    done_d = 1'b0;
    case (st_q)
      MUL_IDLE: begin
        if (req_i.start) st_d = MUL_LO;
      end
      MUL_LO: begin
        acc_d = ACC_W'(pp);
        st_d  = MUL_HI;
      end
      MUL_HI: begin
        acc_d  = acc_q + (ACC_W'(pp) << H_W);
        done_d = 1'b1;
        st_d   = MUL_IDLE;
      end
      default: st_d = MUL_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= MUL_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (st_q == MUL_IDLE && req_i.start) begin
      ma_q  <= abs_a[OP_W-1:0];
      mb_q  <= abs_b[OP_W-1:0];
      neg_q <= req_i.a[Z_W-1] ^ req_i.b[Z_W-1];
    end
  end

  // magnitude truncated toward zero, sign applied after
  assign mag        = acc_q[ACC_W-1:FRAC_BITS];
  assign rsp_o.done = done_q;
  assign rsp_o.p    = neg_q ? -$signed(mag) : $signed(mag);

endmodule

### rtl/mbe_color.sv
// colour ramp: three lanes of count times base, restoring divide by max_iterations, mod 255
// depends on mbe_pkg
module mbe_color (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [mbe_pkg::CNT_W-1:0]    count_i,
  input  logic [mbe_pkg::CNT_W-1:0]    max_iter_i,
  input  logic [mbe_pkg::BASE_W-1:0]   base_i,
  output logic                         done_o,
  output logic [mbe_pkg::CH_W-1:0]     red_o,
  output logic [mbe_pkg::CH_W-1:0]     green_o,
  output logic [mbe_pkg::CH_W-1:0]     blue_o
);
  import mbe_pkg::*;

  localparam int LANES  = 3;
  localparam int NUM_W  = CNT_W + CH_W;
  localparam int STEP_W = $clog2(NUM_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_W - 1);
  localparam logic [CH_W:0]     COL_MOD   = (CH_W + 1)'(255);
  localparam logic [CH_W:0]     COL_MOD2  = (CH_W + 1)'(510);

  logic              run_q, fin_q, done_q;
  logic [STEP_W-1:0] step_q;
  logic [NUM_W-1:0]  q_q   [LANES];
  logic [CNT_W-1:0]  rem_q [LANES];
  logic [CH_W-1:0]   b_q   [LANES];
  logic [CH_W-1:0]   ch_q  [LANES];

  logic [CH_W-1:0]   b_in   [LANES];
  logic [NUM_W-1:0]  num_in [LANES];
  logic [CNT_W:0]    rem_sh [LANES];
  logic              ge     [LANES];
  logic [CNT_W-1:0]  rem_nx [LANES];
  logic [NUM_W-1:0]  q_nx   [LANES];
  logic [CH_W-1:0]   ramp   [LANES];
  logic [CH_W:0]     sum    [LANES];
  logic [CH_W-1:0]   ch_nx  [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      b_in[l]   = base_i[(LANES-1-l)*CH_W +: CH_W];
      num_in[l] = NUM_W'(count_i) * NUM_W'(b_in[l]);
      rem_sh[l] = {rem_q[l], q_q[l][NUM_W-1]};
      ge[l]     = rem_sh[l] >= {1'b0, max_iter_i};
      rem_nx[l] = ge[l] ? CNT_W'(rem_sh[l] - {1'b0, max_iter_i}) : rem_sh[l][CNT_W-1:0];
      q_nx[l]   = {q_q[l][NUM_W-2:0], ge[l]};
      // zero limit gives no ramp
      ramp[l]   = (max_iter_i == '0) ? '0 : q_q[l][CH_W-1:0];
      sum[l]    = {1'b0, b_q[l]} + {1'b0, ramp[l]};
      if (sum[l] >= COL_MOD2) begin
        ch_nx[l] = '0;
      end else if (sum[l] >= COL_MOD) begin
        ch_nx[l] = CH_W'(sum[l] - COL_MOD);
      end else begin
        ch_nx[l] = sum[l][CH_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= run_q && (step_q == LAST_STEP);
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == LAST_STEP) run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < LANES; l++) begin
      if (start_i) begin
        q_q[l]   <= num_in[l];
        rem_q[l] <= '0;
        b_q[l]   <= b_in[l];
      end else if (run_q) begin
        q_q[l]   <= q_nx[l];
        rem_q[l] <= rem_nx[l];
      end
      if (fin_q) ch_q[l] <= ch_nx[l];
    end
  end

  assign done_o  = done_q;
  assign red_o   = ch_q[0];
  assign green_o = ch_q[1];
  assign blue_o  = ch_q[2];

endmodule

### rtl/mandelbrot_escape_time_pixel.sv
// mandelbrot escape time pixel: sequencer over one shared multiplier, uses mbe_pkg,
// mbe_cmap, mbe_mul and mbe_color; one pixel at a time, busy from accept to the result strobe
// each pixel runs the mapping, then three products on the shared multiplier per iteration step,
// then the colour divide
// the next start is taken in the strobe cycle; results cannot be held off
// asynchronous active-low reset returns to idle with registers at their reset values
module mandelbrot_escape_time_pixel (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [mbe_pkg::COORD_BITS-1:0]  pixel_x_i,
  input  logic [mbe_pkg::COORD_BITS-1:0]  pixel_y_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mbe_pkg::IDX_W-1:0]       cfg_index_i,
  input  logic [mbe_pkg::CFG_W-1:0]       cfg_data_i,
  output logic                            done_o,
  output logic [mbe_pkg::COORD_BITS-1:0]  out_x_o,
  output logic [mbe_pkg::COORD_BITS-1:0]  out_y_o,
  output logic [mbe_pkg::CNT_W-1:0]       escape_count_o,
  output logic [mbe_pkg::CH_W-1:0]        red_o,
  output logic [mbe_pkg::CH_W-1:0]        green_o,
  output logic [mbe_pkg::CH_W-1:0]        blue_o
);
  import mbe_pkg::*;

  localparam int S_W  = FRAC_BITS + 10;
  localparam int SQ_W = P_W + 1;
  localparam logic signed [Z_W-1:0]  TWO     = Z_W'(2) << FRAC_BITS;
  localparam logic signed [Z_W-1:0]  NEG_TWO = -TWO;
  localparam logic signed [SQ_W-1:0] FOUR    = SQ_W'(4) << FRAC_BITS;

  function automatic logic signed [Z_W-1:0] clamp_z(input logic signed [S_W-1:0] v);
    logic signed [S_W-1:0] hi;
    logic signed [S_W-1:0] lo;
    logic signed [Z_W-1:0] r;
    hi = S_W'(ZMAX);
    lo = S_W'(ZMIN);
    if (v > hi) begin
      r = ZMAX;
    end else if (v < lo) begin
      r = ZMIN;
    end else begin
      r = v[Z_W-1:0];
    end
    return r;
  endfunction

  cfg_t                    cfg_q;
  st_e                     state_q, state_d;
  logic                    go_q;
  logic                    done_q, done_d;

  logic [COORD_BITS-1:0]   px_q, px_d, py_q, py_d;
  logic signed [Z_W-1:0]   zr_q, zr_d, zi_q, zi_d;
  logic signed [P_W-1:0]   sr_q, sr_d, si_q, si_d, p_q, p_d;
  logic [CNT_W-1:0]        n_q, n_d;

  logic [COORD_BITS-1:0]   out_x_q, out_y_q;
  logic [CNT_W-1:0]        count_q;
  logic [CH_W-1:0]         red_q, green_q, blue_q;

  logic                    map_done;
  logic signed [Z_W-1:0]   cr, ci;
  mul_req_t                mul_req;
  mul_rsp_t                mul_rsp;
  logic                    col_done;
  logic [CH_W-1:0]         col_red, col_green, col_blue;

  logic                    escaped;
  logic signed [SQ_W-1:0]  sq_sum;

  // configuration beats
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_WIDTH:    cfg_q.width    <= cfg_data_i[IMG_W-1:0];
        REG_HEIGHT:   cfg_q.height   <= cfg_data_i[IMG_W-1:0];
        REG_CENTER_X: cfg_q.center_x <= cfg_data_i[CTR_W-1:0];
        REG_CENTER_Y: cfg_q.center_y <= cfg_data_i[CTR_W-1:0];
        REG_PITCH:    cfg_q.pitch    <= cfg_data_i[PITCH_W-1:0];
        REG_MAX_ITER: cfg_q.max_iter <= cfg_data_i[CNT_W-1:0];
        REG_BASE:     cfg_q.base     <= cfg_data_i[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  mbe_cmap u_cmap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (go_q && state_q == ST_MAP),
    .cfg_i   (cfg_q),
    .px_i    (px_q),
    .py_i    (py_q),
    .done_o  (map_done),
    .cr_o    (cr),
    .ci_o    (ci)
  );

  always_comb begin
    mul_req.start = go_q && (state_q == ST_ZP || state_q == ST_SR || state_q == ST_SI);
    mul_req.a     = (state_q == ST_SI) ? zi_q : zr_q;
    mul_req.b     = (state_q == ST_ZP || state_q == ST_SI) ? zi_q : zr_q;
  end

  mbe_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  mbe_color u_color (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (go_q && state_q == ST_COLOR),
    .count_i    (n_q),
    .max_iter_i (cfg_q.max_iter),
    .base_i     (cfg_q.base),
    .done_o     (col_done),
    .red_o      (col_red),
    .green_o    (col_green),
    .blue_o     (col_blue)
  );

  assign escaped = (zr_q > TWO) || (zr_q < NEG_TWO) || (zi_q > TWO) || (zi_q < NEG_TWO);
  assign sq_sum  = SQ_W'(sr_q) + SQ_W'(si_q);

  always_comb begin
    state_d = state_q;
    px_d    = px_q;
    py_d    = py_q;
    zr_d    = zr_q;
    zi_d    = zi_q;
    sr_d    = sr_q;
    si_d    = si_q;
    p_d     = p_q;
    n_d     = n_q;
    done_d  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          px_d    = pixel_x_i;
          py_d    = pixel_y_i;
          zr_d    = '0;
          zi_d    = '0;
          sr_d    = '0;
          si_d    = '0;
          n_d     = '0;
          state_d = ST_MAP;
        end
      end
      ST_MAP: begin
        if (map_done) state_d = ST_ZP;
      end
      ST_ZP: begin
        if (mul_rsp.done) begin
          p_d     = mul_rsp.p;
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        zr_d    = clamp_z(S_W'(sr_q) - S_W'(si_q) + S_W'(cr));
        zi_d    = clamp_z((S_W'(p_q) <<< 1) + S_W'(ci));
        state_d = ST_CHK;
      end
      ST_CHK: begin
        state_d = escaped ? ST_COLOR : ST_SR;
      end
      ST_SR: begin
        if (mul_rsp.done) begin
          sr_d    = mul_rsp.p;
          state_d = ST_SI;
        end
      end
      ST_SI: begin
        if (mul_rsp.done) begin
          si_d    = mul_rsp.p;
          state_d = ST_TEST;
        end
      end
      ST_TEST: begin
        if (sq_sum > FOUR || n_q == cfg_q.max_iter) begin
          state_d = ST_COLOR;
        end else begin
          n_d     = n_q + CNT_W'(1);
          state_d = ST_ZP;
        end
      end
      ST_COLOR: begin
        if (col_done) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      go_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      go_q    <= (state_d != state_q);
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q <= px_d;
    py_q <= py_d;
    zr_q <= zr_d;
    zi_q <= zi_d;
    sr_q <= sr_d;
    si_q <= si_d;
    p_q  <= p_d;
    n_q  <= n_d;
    if (done_d) begin
      out_x_q <= px_q;
      out_y_q <= py_q;
      count_q <= n_q;
      red_q   <= col_red;
      green_q <= col_green;
      blue_q  <= col_blue;
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign out_x_o        = out_x_q;
  assign out_y_o        = out_y_q;
  assign escape_count_o = count_q;
  assign red_o          = red_q;
  assign green_o        = green_q;
  assign blue_o         = blue_q;

endmodule

### rtl/mbe_chk.sv
// port checker for the mandelbrot escape time pixel block, bound to the top level
// depends on mbe_pkg and mandelbrot_escape_time_pixel_macros.svh
`include "mandelbrot_escape_time_pixel_macros.svh"

module mbe_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start_i,
  input logic                         busy_o,
  input logic                         done_o,
  input logic [mbe_pkg::CH_W-1:0]     red_o,
  input logic [mbe_pkg::CH_W-1:0]     green_o,
  input logic [mbe_pkg::CH_W-1:0]     blue_o
);

  // an accepted beat keeps the block busy
  `MBE_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start_i && !busy_o, busy_o)
  // a result only ends a busy period
  `MBE_ASSERT_SAME(a_done_after_busy, clk_i, rst_ni, done_o, $past(busy_o))
  // strobe lasts one cycle
  `MBE_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o)
  // channels are reduced mod 255
  `MBE_ASSERT_SAME(a_color_range, clk_i, rst_ni, done_o,
                   red_o != 8'hFF && green_o != 8'hFF && blue_o != 8'hFF)

endmodule

bind mandelbrot_escape_time_pixel mbe_chk u_mbe_chk (.*);

### verif/tb.sv
// self-checking bench for mandelbrot_escape_time_pixel: directed views, then random views
// predicts escape count and colour per pixel in fixed point; needs only mbe_pkg and the rtl
module tb;
  import mbe_pkg::*;

  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam longint Z_LIMIT = longint'(1) << (FRAC_BITS + 7);
  localparam longint Q_TWO = longint'(2) << FRAC_BITS;
  localparam longint Q_FOUR = longint'(4) << FRAC_BITS;
  localparam longint unsigned C_CAP = 64'd1 << (PITCH_FRAC + 8);
  localparam int VIEWS = 10;
  localparam int PIXELS_PER_VIEW = 93;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } pixel_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [CNT_W-1:0]      count;
    logic [CH_W-1:0]       red;
    logic [CH_W-1:0]       green;
    logic [CH_W-1:0]       blue;
  } shade_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start_i = 1'b0;
  logic                  busy_o;
  logic [COORD_BITS-1:0] pixel_x_i = '0;
  logic [COORD_BITS-1:0] pixel_y_i = '0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [IDX_W-1:0]      cfg_index_i = '0;
  logic [CFG_W-1:0]      cfg_data_i = '0;
  logic                  done_o;
  logic [COORD_BITS-1:0] out_x_o;
  logic [COORD_BITS-1:0] out_y_o;
  logic [CNT_W-1:0]      escape_count_o;
  logic [CH_W-1:0]       red_o;
  logic [CH_W-1:0]       green_o;
  logic [CH_W-1:0]       blue_o;

  cfg_t view_regs = '{
    width:    12'd900,
    height:   12'd700,
    center_x: 16'sd450,
    center_y: 16'sd350,
    pitch:    28'd671089,
    max_iter: 12'd42,
    base:     24'h00FF00
  };

  pixel_t pixel_backlog[$];
  shade_t shades_in_flight[$];
  shade_t oldest_shade;
  shade_t seen_shade;
  int     shade_errors = 0;
  int     pixels_accepted = 0;
  int     pixels_shaded = 0;
  int     inner_pixels = 0;
  int     settings_count = 1;

  mandelbrot_escape_time_pixel dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .pixel_x_i      (pixel_x_i),
    .pixel_y_i      (pixel_y_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .out_x_o        (out_x_o),
    .out_y_o        (out_y_o),
    .escape_count_o (escape_count_o),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic longint clamp_q(longint v);
    if (v >= Z_LIMIT) return Z_LIMIT - 1;
    if (v < -Z_LIMIT) return -Z_LIMIT;
    return v;
  endfunction

  // half-pixel offset to a point of the plane, saturated
  function automatic longint to_plane(longint d);
    longint unsigned mag;
    mag = (d < 0) ? -d : d;
    mag = mag * view_regs.pitch;
    if (mag > C_CAP) mag = C_CAP;
    if (FRAC_BITS > PITCH_FRAC) mag = mag << (FRAC_BITS - PITCH_FRAC - 1);
    else mag = mag >> (PITCH_FRAC + 1 - FRAC_BITS);
    if (mag >= Z_LIMIT) return (d < 0) ? -Z_LIMIT : Z_LIMIT - 1;
    return (d < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  // exact product, magnitude truncated to the fraction width
  function automatic longint mul_q(longint a, longint b);
    logic [127:0]    prod;
    longint unsigned ma;
    longint unsigned mb;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    prod = {64'd0, ma} * {64'd0, mb};
    prod = prod >> FRAC_BITS;
    return ((a < 0) != (b < 0)) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  function automatic logic [CH_W-1:0] ramp_channel(logic [CH_W-1:0] b, int count);
    int unsigned ramp;
    ramp = (view_regs.max_iter == 0) ? 0 : (count * b) / view_regs.max_iter;
    return (b + ramp) % 255;
  endfunction

  function automatic shade_t shade_pixel(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py);
    longint w, h, dx, dy, cr, ci, zr, zi, sr, si, p;
    int     n, count, m;
    shade_t res;
    w = view_regs.width;
    h = view_regs.height;
    m = view_regs.max_iter;
    dx = 2 * longint'(px) + 2 * longint'(view_regs.center_x) - 2 * (w >>> 1) - w;
    dy = h + 2 * (h >>> 1) - 2 * longint'(py) - 2 * longint'(view_regs.center_y);
    cr = to_plane(dx);
    ci = to_plane(dy);
    zr = 0;
    zi = 0;
    sr = 0;
    si = 0;
    count = 0;
    for (n = 0; n <= m; n++) begin
      p = mul_q(zr, zi);
      count = n;
      zr = clamp_q(sr - si + cr);
      zi = clamp_q(2 * p + ci);
      if (zr > Q_TWO || zr < -Q_TWO || zi > Q_TWO || zi < -Q_TWO) break;
      sr = mul_q(zr, zr);
      si = mul_q(zi, zi);
      if (sr + si > Q_FOUR) break;
    end
    res.x = px;
    res.y = py;
    res.count = count[CNT_W-1:0];
    res.red = ramp_channel(view_regs.base[23:16], count);
    res.green = ramp_channel(view_regs.base[15:8], count);
    res.blue = ramp_channel(view_regs.base[7:0], count);
    return res;
  endfunction

  // pixel driver, holds start until taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        shades_in_flight.push_back(shade_pixel(pixel_x_i, pixel_y_i));
        if (shades_in_flight[$].count == view_regs.max_iter) inner_pixels++;
        pixels_accepted++;
      end
      if (!start_i || !busy_o) begin
        if (pixel_backlog.size() != 0 &&
            ((pixels_accepted >= 300 && pixels_accepted < 420) ||
             $urandom_range(99) >= 31)) begin
          start_i <= 1'b1;
          pixel_x_i <= pixel_backlog[0].x;
          pixel_y_i <= pixel_backlog[0].y;
          pixel_backlog.pop_front();
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      seen_shade = '{out_x_o, out_y_o, escape_count_o, red_o, green_o, blue_o};
      if (shades_in_flight.size() == 0) begin
        shade_errors++;
        if (shade_errors <= 10)
          $display("tb: result with nothing in flight: x %0d y %0d count %0d",
                   out_x_o, out_y_o, escape_count_o);
      end else begin
        oldest_shade = shades_in_flight.pop_front();
        pixels_shaded++;
        if (seen_shade !== oldest_shade) begin
          shade_errors++;
          if (shade_errors <= 10) begin
            $display("tb: mismatch exp x %0d y %0d count %0d rgb %0d/%0d/%0d",
                     oldest_shade.x, oldest_shade.y, oldest_shade.count,
                     oldest_shade.red, oldest_shade.green, oldest_shade.blue);
            $display("tb:          got x %0d y %0d count %0d rgb %0d/%0d/%0d",
                     seen_shade.x, seen_shade.y, seen_shade.count,
                     seen_shade.red, seen_shade.green, seen_shade.blue);
          end
        end
      end
    end
  end

  // one register beat per call
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    repeat (1 + (($urandom_range(99) < 31) ? $urandom_range(1, 3) : 0)) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_WIDTH:    view_regs.width = data[IMG_W-1:0];
      REG_HEIGHT:   view_regs.height = data[IMG_W-1:0];
      REG_CENTER_X: view_regs.center_x = data[CTR_W-1:0];
      REG_CENTER_Y: view_regs.center_y = data[CTR_W-1:0];
      REG_PITCH:    view_regs.pitch = data[PITCH_W-1:0];
      REG_MAX_ITER: view_regs.max_iter = data[CNT_W-1:0];
      REG_BASE:     view_regs.base = data[BASE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_view(int w, int h, int cx, int cy, int pitch, int m, int base);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_PITCH, pitch);
    write_reg(REG_MAX_ITER, m);
    write_reg(REG_BASE, base);
    settings_count++;
  endtask

  task automatic queue_pixel(int x, int y);
    pixel_t item;
    item.x = x[COORD_BITS-1:0];
    item.y = y[COORD_BITS-1:0];
    pixel_backlog.push_back(item);
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pixel_backlog.size() != 0 || shades_in_flight.size() != 0 || start_i || busy_o);
  endtask

  initial begin : stimulus
    int w, h, cx, cy, m, pitch, base_px, base_py, span, view_idx, i;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset view, corners and the view center
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    queue_pixel(0, 4095);
    queue_pixel(4095, 0);
    queue_pixel(450, 350);
    queue_pixel(12'hAAA, 12'h555);
    wait_idle();

    // zero iteration limit, full white base
    program_view(900, 700, 450, 350, 671089, 0, 24'hFFFFFF);
    queue_pixel(450, 350);
    queue_pixel(0, 0);
    queue_pixel(12'h555, 12'hAAA);
    wait_idle();

    // zero pitch and zero size, then a write to an unused index
    program_view(0, 0, 0, 0, 0, 7, 24'h000000);
    write_reg(REG_UNUSED, 28'hFFFFFFF);
    queue_pixel(4095, 0);
    queue_pixel(123, 3000);
    wait_idle();

    // far coordinates, both saturation directions
    program_view(4095, 4095, 32767, -32768, 28'hFFFFFFF, 4095, 24'h000000);
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    queue_pixel(0, 4095);
    queue_pixel(4095, 0);
    wait_idle();
    program_view(4095, 4095, -32768, 32767, 28'hFFFFFFF, 4095, 24'hFFFFFF);
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    wait_idle();

    // one pixel that never escapes at the largest limit
    program_view(1, 1, 0, 0, 1, 4095, 24'h80FF01);
    queue_pixel(0, 0);
    wait_idle();

    for (view_idx = 0; view_idx < VIEWS; view_idx++) begin
      w = $urandom_range(1, 4095);
      h = $urandom_range(1, 4095);
      pitch = (view_idx == VIEWS - 1) ? $urandom_range(1, 28'hFFFFFFF)
                                      : $urandom_range(1 << 19, 1 << 23);
      m = (view_idx == 0) ? 1 : $urandom_range(2, 40);
      base_px = $urandom_range(0, 4095);
      base_py = $urandom_range(0, 4095);
      if (view_idx == VIEWS - 2) begin
        cx = int'($urandom_range(0, 65535)) - 32768;
        cy = int'($urandom_range(0, 65535)) - 32768;
      end else begin
        cx = w / 2 + (w + 1) / 2 - base_px;
        cy = (h + 2 * (h / 2)) / 2 - base_py;
      end
      // pixel spread that keeps c within about 2.5 of the origin
      span = (5 << 27) / pitch;
      if (span > 2047) span = 2047;
      if (span < 1) span = 1;
      program_view(w, h, cx, cy, pitch, m, $urandom_range(0, 24'hFFFFFF));
      for (i = 0; i < PIXELS_PER_VIEW; i++) begin
        if ($urandom_range(99) < 80)
          queue_pixel(base_px + int'($urandom_range(0, 2 * span)) - span,
                      base_py + int'($urandom_range(0, 2 * span)) - span);
        else
          queue_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
      end
      wait_idle();
    end

    repeat (200) @(posedge clk_i);
    $display("tb: %0d pixels shaded under %0d register settings, %0d hit the limit",
             pixels_shaded, settings_count, inner_pixels);
    if (shade_errors == 0 && shades_in_flight.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("tb: %0d mismatches, %0d results missing", shade_errors,
               shades_in_flight.size());
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("tb: timeout with %0d results outstanding", shades_in_flight.size());
    $display("FAILURE");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/mbe_pkg.sv
rtl/mbe_cmap.sv
rtl/mbe_mul.sv
rtl/mbe_color.sv
rtl/mandelbrot_escape_time_pixel.sv
rtl/mbe_chk.sv
verif/tb.sv
